// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define BBT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising clock edge, reset included.
`define BBT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- rtl/core/bbt_pkg.sv -----
`default_nettype none

package bbt_pkg;

    localparam int ADDR_W    = 16;
    localparam int WORD_BITS = 32;
    localparam int ROWS      = 2048;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int WIDX_W    = ADDR_W - BIT_W;
    localparam int LAST_ROW  = ((ROWS < 2 ** WIDX_W) ? ROWS : 2 ** WIDX_W) - 1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [2:0] {
        FN_SET     = 3'd0,
        FN_CLR     = 3'd1,
        FN_CLR_ALL = 3'd2,
        FN_TEST    = 3'd3,
        FN_FIND    = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_CLEAR,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [2:0]        func;
        logic [ADDR_W-1:0] addr;
    } t_in;

    typedef struct packed {
        logic              is_set;
        logic              found;
        logic [ADDR_W-1:0] found_addr;
        logic              changed_notice;
    } t_out;

endpackage

`default_nettype wire

// ----- rtl/core/breakpoint_bitmap_table.sv -----
// Set, clear and test: one word read-modify-write (test only reads), result loaded in ST_RMW.
// Find-next: steps k words past the start word, one memory read per cycle until it stops.
// Clear-all: a write sweep of all ROWS words of the flag memory, then a change notice.
// One item in flight; the output register lets the next input transfer while a result waits.
// Synchronous active-low reset, then a clearing pass of all rows; no input is taken during it.
`default_nettype none

module breakpoint_bitmap_table (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bbt_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output bbt_pkg::t_out      o_out_data
);

    bbt_pkg::t_word r_mem [bbt_pkg::ROWS];
    bbt_pkg::t_word r_rd_data;

    bbt_pkg::t_state r_state, n_state;
    logic [2:0]                 r_func, n_func;
    logic [bbt_pkg::BIT_W-1:0]  r_bit, n_bit;
    logic [bbt_pkg::ROW_W-1:0]  r_widx, n_widx;
    logic                       r_in_map, n_in_map;
    logic                       r_first, n_first;
    logic [bbt_pkg::ROW_W-1:0]  r_cnt, n_cnt;
    logic                       r_out_valid;
    bbt_pkg::t_out              r_out;

    logic                       mem_we, mem_re;
    logic [bbt_pkg::ROW_W-1:0]  mem_wa, mem_ra;
    bbt_pkg::t_word             mem_wd;
    logic                       in_ready, in_fire, out_free, out_load;
    bbt_pkg::t_out              out_res;
    logic [bbt_pkg::WIDX_W-1:0] in_widx;
    logic                       in_map_c;
    bbt_pkg::t_word             scan_mask, bit_sel;
    logic                       scan_hit, scan_stop, cnt_last;

    function automatic logic [bbt_pkg::BIT_W-1:0] first_set(input bbt_pkg::t_word v);
        logic [bbt_pkg::BIT_W-1:0] r;
        r = '0;
        for (int i = bbt_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = bbt_pkg::BIT_W'(i);
            end
        end
        return r;
    endfunction

    assign in_fire   = i_in_valid && in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign in_widx   = i_in_data.addr[bbt_pkg::ADDR_W-1:bbt_pkg::BIT_W];
    assign in_map_c  = int'(in_widx) < bbt_pkg::ROWS;
    assign bit_sel   = bbt_pkg::t_word'(1) << r_bit;
    assign scan_mask = r_rd_data & (r_first ? ({bbt_pkg::WORD_BITS{1'b1}} << r_bit)
                                            : {bbt_pkg::WORD_BITS{1'b1}});
    assign scan_hit  = r_in_map && (scan_mask != '0);
    assign scan_stop = !r_in_map || scan_hit
                    || (r_widx == bbt_pkg::ROW_W'(bbt_pkg::LAST_ROW));
    assign cnt_last  = r_cnt == bbt_pkg::ROW_W'(bbt_pkg::ROWS - 1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbt_pkg::ST_INIT: begin
                if (cnt_last) begin
                    n_state = bbt_pkg::ST_IDLE;
                end
            end
            bbt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    unique case (bbt_pkg::t_func'(i_in_data.func))
                        bbt_pkg::FN_SET,
                        bbt_pkg::FN_CLR,
                        bbt_pkg::FN_TEST:    n_state = bbt_pkg::ST_RMW;
                        bbt_pkg::FN_FIND:    n_state = bbt_pkg::ST_SCAN;
                        bbt_pkg::FN_CLR_ALL: n_state = bbt_pkg::ST_CLEAR;
                        default:             n_state = bbt_pkg::ST_RESP;
                    endcase
                end
            end
            bbt_pkg::ST_RMW: begin
                if (out_free) begin
                    n_state = bbt_pkg::ST_IDLE;
                end
            end
            bbt_pkg::ST_SCAN: begin
                if (scan_stop && out_free) begin
                    n_state = bbt_pkg::ST_IDLE;
                end
            end
            bbt_pkg::ST_CLEAR: begin
                if (cnt_last) begin
                    n_state = bbt_pkg::ST_RESP;
                end
            end
            bbt_pkg::ST_RESP: begin
                if (out_free) begin
                    n_state = bbt_pkg::ST_IDLE;
                end
            end
            default: n_state = bbt_pkg::ST_INIT;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_func   = r_func;
        n_bit    = r_bit;
        n_widx   = r_widx;
        n_in_map = r_in_map;
        n_first  = r_first;
        n_cnt    = r_cnt;
        mem_we   = 1'b0;
        mem_wa   = r_widx;
        mem_wd   = r_rd_data;
        mem_re   = 1'b0;
        mem_ra   = r_widx;
        in_ready = 1'b0;
        out_load = 1'b0;
        out_res  = '0;
        unique case (r_state)
            bbt_pkg::ST_INIT,
            bbt_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt;
                mem_wd = '0;
                n_cnt  = r_cnt + 1'b1;
            end
            bbt_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    n_func   = i_in_data.func;
                    n_bit    = i_in_data.addr[bbt_pkg::BIT_W-1:0];
                    n_widx   = bbt_pkg::ROW_W'(in_widx);
                    n_in_map = in_map_c;
                    n_first  = 1'b1;
                    n_cnt    = '0;
                    mem_re   = 1'b1;
                    mem_ra   = bbt_pkg::ROW_W'(in_widx);
                end
            end
            bbt_pkg::ST_RMW: begin
                if (out_free) begin
                    out_load = 1'b1;
                    unique case (bbt_pkg::t_func'(r_func))
                        bbt_pkg::FN_SET: begin
                            mem_we = r_in_map;
                            mem_wd = r_rd_data | bit_sel;
                            out_res.changed_notice = 1'b1;
                        end
                        bbt_pkg::FN_CLR: begin
                            mem_we = r_in_map;
                            mem_wd = r_rd_data & ~bit_sel;
                            out_res.changed_notice = 1'b1;
                        end
                        bbt_pkg::FN_TEST: begin
                            out_res.is_set = r_in_map && r_rd_data[r_bit];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bbt_pkg::ST_SCAN: begin
                if (scan_stop) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        if (scan_hit) begin
                            out_res.found      = 1'b1;
                            out_res.found_addr = bbt_pkg::ADDR_W'({r_widx,
                                                                   first_set(scan_mask)});
                        end
                    end
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_widx + 1'b1;
                    n_widx  = r_widx + 1'b1;
                    n_first = 1'b0;
                end
            end
            bbt_pkg::ST_RESP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_res.changed_notice =
                        bbt_pkg::t_func'(r_func) == bbt_pkg::FN_CLR_ALL;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbt_pkg::ST_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_bit    <= n_bit;
        r_widx   <= n_widx;
        r_in_map <= n_in_map;
        r_first  <= n_first;
        if (out_load) begin
            r_out <= out_res;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/bbt_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module bbt_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire bbt_pkg::t_out o_out_data
);

    `BBT_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `BBT_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")
    `BBT_ASSERT(a_notice_alone, i_clk, i_rst_n, o_out_valid && o_out_data.changed_notice |-> !o_out_data.is_set && !o_out_data.found, "change notice mixed with query result")
    `BBT_ASSERT(a_addr_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.found |-> o_out_data.found_addr == '0, "address given without a hit")

endmodule

bind breakpoint_bitmap_table bbt_checker u_bbt_checker (.*);

`default_nettype wire
